/* sv/yhp_pkg.sv */
// Shared types, widths and register codes for the yaw hold position PID.
`default_nettype none

package yhp_pkg;

   localparam int ENCODER_BITS = 13;
   localparam int FRAC_BITS    = 16;
   localparam int GAIN_W       = 32;
   localparam int SPEED_W      = 16;
   localparam int LIMIT_W      = 15;
   localparam int CURRENT_W    = 16;

   localparam int ERR_W    = ENCODER_BITS + 1;
   localparam int PROD_P_W = GAIN_W + ERR_W;
   localparam int PROD_D_W = GAIN_W + SPEED_W;
   localparam int ACC_W    = ((PROD_P_W > PROD_D_W) ? PROD_P_W : PROD_D_W) + 2;
   localparam int ISUM_W   = LIMIT_W + FRAC_BITS + 1;

   localparam int ADDR_W = 5;
   localparam int IDX_W  = ADDR_W - 2;
   localparam int DATA_W = 32;

   localparam logic [IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
   localparam logic [IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
   localparam logic [IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
   localparam logic [IDX_W-1:0] REG_INTEG_LIMIT = 3'd3;
   localparam logic [IDX_W-1:0] REG_OUTPUT_LIMIT = 3'd4;

   typedef struct packed {
      logic [ENCODER_BITS-1:0]   encoder_position;
      logic signed [SPEED_W-1:0] rotor_speed;
      logic                      work_mode;
   } req_type;

   typedef struct packed {
      logic signed [CURRENT_W-1:0] drive_current;
      logic                        locked;
   } rsp_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] prop_gain;
      logic signed [GAIN_W-1:0] integ_gain;
      logic signed [GAIN_W-1:0] deriv_gain;
      logic [LIMIT_W-1:0]       integrator_limit;
      logic [LIMIT_W-1:0]       output_limit;
   } cfg_type;

   typedef struct packed {
      logic                     was_locked;
      logic [ENCODER_BITS-1:0]  hold_target;
      logic signed [ISUM_W-1:0] integral_sum;
   } pid_state_type;

endpackage

`default_nettype wire

/* sv/yhp_csr.sv */
// APB-style configuration register file for the yaw hold position PID.
`default_nettype none

module yhp_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [yhp_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [yhp_pkg::DATA_W-1:0]  pwdata,
   output logic      [yhp_pkg::DATA_W-1:0]  prdata,
   output logic                             pready,
   output yhp_pkg::cfg_type                 cfg
);
   import yhp_pkg::*;

   cfg_type          cfg_ff;
   cfg_type          cfg_in;
   logic [IDX_W-1:0] index;
   logic             wr_en;

   assign index  = paddr[ADDR_W-1:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_PROP_GAIN:    cfg_in.prop_gain        = $signed(pwdata);
            REG_INTEG_GAIN:   cfg_in.integ_gain       = $signed(pwdata);
            REG_DERIV_GAIN:   cfg_in.deriv_gain       = $signed(pwdata);
            REG_INTEG_LIMIT:  cfg_in.integrator_limit = pwdata[LIMIT_W-1:0];
            REG_OUTPUT_LIMIT: cfg_in.output_limit     = pwdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (index)
         REG_PROP_GAIN:    prdata = cfg_ff.prop_gain;
         REG_INTEG_GAIN:   prdata = cfg_ff.integ_gain;
         REG_DERIV_GAIN:   prdata = cfg_ff.deriv_gain;
         REG_INTEG_LIMIT:  prdata = DATA_W'(cfg_ff.integrator_limit);
         REG_OUTPUT_LIMIT: prdata = DATA_W'(cfg_ff.output_limit);
         default:          prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

/* sv/yhp_pid_math.sv */
// Combinational PID step: target capture, clamped integrator, clamped output.
`default_nettype none

module yhp_pid_math (
   input  wire yhp_pkg::cfg_type       cfg,
   input  wire yhp_pkg::req_type       item,
   input  wire yhp_pkg::pid_state_type state_cur,
   output yhp_pkg::pid_state_type      state_next,
   output yhp_pkg::rsp_type            result
);
   import yhp_pkg::*;

   localparam logic signed [ACC_W-1:0] FRAC_BIAS = ACC_W'((64'd1 << FRAC_BITS) - 64'd1);

   logic [ENCODER_BITS-1:0]    target;
   logic signed [ERR_W-1:0]    err;
   logic signed [PROD_P_W-1:0] p_term;
   logic signed [PROD_P_W-1:0] i_prod;
   logic signed [PROD_D_W-1:0] d_term;
   logic signed [ACC_W-1:0]    ilim;
   logic signed [ACC_W-1:0]    olim;
   logic signed [ACC_W-1:0]    i_raw;
   logic signed [ACC_W-1:0]    i_clamped;
   logic signed [ACC_W-1:0]    sum_raw;
   logic signed [ACC_W-1:0]    sum_clamped;
   logic signed [ACC_W-1:0]    sum_biased;
   logic signed [ACC_W-1:0]    current_full;

   // On the first locked transaction the target is the current position.
   assign target = state_cur.was_locked ? state_cur.hold_target : item.encoder_position;
   assign err    = $signed({1'b0, target}) - $signed({1'b0, item.encoder_position});

   assign p_term = cfg.prop_gain * err;
   assign i_prod = cfg.integ_gain * err;
   assign d_term = cfg.deriv_gain * item.rotor_speed;

   assign ilim = $signed({{(ACC_W-LIMIT_W-FRAC_BITS){1'b0}}, cfg.integrator_limit,
                          {FRAC_BITS{1'b0}}});
   assign olim = $signed({{(ACC_W-LIMIT_W-FRAC_BITS){1'b0}}, cfg.output_limit,
                          {FRAC_BITS{1'b0}}});

   assign i_raw = ACC_W'(state_cur.integral_sum) + ACC_W'(i_prod);

   always_comb begin
      if (i_raw > ilim) begin
         i_clamped = ilim;
      end else if (i_raw < -ilim) begin
         i_clamped = -ilim;
      end else begin
         i_clamped = i_raw;
      end
   end

   assign sum_raw = ACC_W'(p_term) + i_clamped + ACC_W'(d_term);

   always_comb begin
      if (sum_raw > olim) begin
         sum_clamped = olim;
      end else if (sum_raw < -olim) begin
         sum_clamped = -olim;
      end else begin
         sum_clamped = sum_raw;
      end
   end

   // Biasing negative values before the shift makes it truncate toward zero.
   assign sum_biased   = sum_clamped[ACC_W-1] ? sum_clamped + FRAC_BIAS : sum_clamped;
   assign current_full = sum_biased >>> FRAC_BITS;

   always_comb begin
      state_next    = state_cur;
      result.locked = item.work_mode;
      if (item.work_mode) begin
         state_next.was_locked   = 1'b1;
         state_next.hold_target  = target;
         state_next.integral_sum = ISUM_W'(i_clamped);
         result.drive_current    = current_full[CURRENT_W-1:0];
      end else begin
         state_next.was_locked   = 1'b0;
         result.drive_current    = '0;
      end
   end

endmodule

`default_nettype wire

/* sv/yaw_hold_position_pid.sv */
// Top level of the yaw hold position PID controller.
//
// Usage: each transaction on the req channel is one control tick carrying the
// encoder position, the measured speed and the work-mode flag. Every tick
// produces exactly one rsp transaction with the drive current and the lock
// flag, in order. The gains and limits are written over the APB-style port
// while no transaction is in flight; pready is always high.
//
// The input register takes a req transaction at its accepting edge; once
// the result register is free or being read, the PID step, computed in a
// single pass, lands in the result register, where the integrator, the hold
// target and the lock history are updated too. Throughput is one transaction
// per cycle while the receiver does not stall; the loop carried through the
// integrator closes within one pass.
//
// Reset clears the valid flags, the integrator, the hold target and the lock
// history. When the receiver stalls, the result register holds its
// transaction, the input register takes one more, and req_ready then drops
// until rsp_ready returns.
`default_nettype none

module yaw_hold_position_pid (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire yhp_pkg::req_type            req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output yhp_pkg::rsp_type                 rsp_data,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [yhp_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [yhp_pkg::DATA_W-1:0]  pwdata,
   output logic      [yhp_pkg::DATA_W-1:0]  prdata,
   output logic                             pready
);
   import yhp_pkg::*;

   cfg_type       cfg;
   req_type       stage_ff;
   logic          stage_valid_ff;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;
   logic          rsp_valid_ff;
   pid_state_type state_ff;
   pid_state_type state_in;
   logic          advance;

   yhp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   yhp_pid_math u_math (
      .cfg        (cfg),
      .item       (stage_ff),
      .state_cur  (state_ff),
      .state_next (state_in),
      .result     (rsp_in)
   );

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !stage_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_ff <= req_data;
      end
      if (advance && stage_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         state_ff       <= '0;
      end else begin
         if (req_ready) begin
            stage_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= stage_valid_ff;
            if (stage_valid_ff) begin
               state_ff <= state_in;
            end
         end
      end
   end

   // A free-mode result always commands zero current.
   a_free_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.locked |-> rsp_data.drive_current == '0)
      else $error("free-mode transaction with nonzero drive current");

   // The input side only stalls when a result is held by the receiver.
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req_ready low without an output stall");

   // A staged transaction that may advance shows up as a result next cycle.
   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && advance |=> rsp_valid)
      else $error("staged transaction lost on its way to the result register");

   // The lock history follows the last transaction that left the stage.
   a_lock_history: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && advance |=> state_ff.was_locked == rsp_data.locked)
      else $error("lock history does not match the delivered lock flag");

endmodule

`default_nettype wire

/* tb/yaw_hold_position_pid_test.sv */
// Self-checking testbench for the yaw hold position PID controller.
module yaw_hold_position_pid_test;
   import yhp_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int DRAIN_CYCLES   = 8;
   localparam int REPORT_LIMIT   = 10;
   localparam int RECONFIG_EVERY = 150;

   // Register slots that the block decodes to nothing.
   localparam logic [IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
   localparam logic [IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              psel      = 1'b0;
   logic              penable   = 1'b0;
   logic              pwrite    = 1'b0;
   logic [ADDR_W-1:0] paddr     = '0;
   logic [DATA_W-1:0] pwdata    = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   // Predicted configuration and controller state.
   int                      kp         = 0;
   int                      ki         = 0;
   int                      kd         = 0;
   logic [LIMIT_W-1:0]      integ_lim  = '0;
   logic [LIMIT_W-1:0]      out_lim    = '0;
   logic                    lock_prev  = 1'b0;
   logic [ENCODER_BITS-1:0] target_pos = '0;
   longint                  integ_acc  = 0;

   rsp_type expected_q[$];
   int      mismatches    = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   logic    holdoff_request = 1'b0;
   logic    rsp_holdoff     = 1'b0;
   logic [ENCODER_BITS-1:0] gen_target = '0;

   yaw_hold_position_pid i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(CLK_PERIOD * 400_000);
      $display("end of test: mismatches");
      $finish;
   end

   function automatic longint clamp_mag(input longint v, input longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // One control tick of the PID; updates the predicted state.
   function automatic rsp_type predict_tick(input req_type t);
      longint  err, p_term, d_term, total, ilim, olim;
      rsp_type r;
      r.drive_current = '0;
      r.locked        = t.work_mode;
      if (t.work_mode) begin
         ilim = longint'(integ_lim) << FRAC_BITS;
         olim = longint'(out_lim) << FRAC_BITS;
         if (!lock_prev) target_pos = t.encoder_position;
         err       = longint'(target_pos) - longint'(t.encoder_position);
         p_term    = longint'(kp) * err;
         integ_acc = clamp_mag(integ_acc + longint'(ki) * err, ilim);
         d_term    = longint'(kd) * longint'($signed(t.rotor_speed));
         total     = clamp_mag(p_term + integ_acc + d_term, olim);
         r.drive_current = CURRENT_W'(total / (longint'(1) << FRAC_BITS));
      end
      lock_prev = t.work_mode;
      return r;
   endfunction

   function automatic req_type tick_of(input int pos, input int speed, input logic mode);
      req_type t;
      t.encoder_position = ENCODER_BITS'(pos);
      t.rotor_speed      = SPEED_W'(speed);
      t.work_mode        = mode;
      return t;
   endfunction

   // Either a tick near the current hold point or one with fully random fields.
   function automatic req_type make_tick(input logic mode, input logic wild);
      req_type t;
      t.work_mode = mode;
      if (wild) begin
         t.encoder_position = ENCODER_BITS'($urandom());
         t.rotor_speed      = SPEED_W'($urandom());
      end else begin
         t.encoder_position = ENCODER_BITS'(int'(gen_target) + int'($urandom_range(128)) - 64);
         t.rotor_speed      = SPEED_W'(int'($urandom_range(400)) - 200);
      end
      return t;
   endfunction

   function automatic logic [DATA_W-1:0] pick_gain();
      int v;
      case ($urandom_range(4))
         0: v = $urandom();
         1: v = int'($urandom_range(262143)) - 131072;
         2: v = int'($urandom_range(8191)) - 4096;
         3: v = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: v = 0;
      endcase
      return v;
   endfunction

   // Limits carry random junk above bit 14, which the block must drop.
   function automatic logic [DATA_W-1:0] pick_limit();
      logic [LIMIT_W-1:0] lim;
      case ($urandom_range(3))
         0: lim = '0;
         1: lim = '1;
         2: lim = LIMIT_W'($urandom_range(200, 1));
         default: lim = LIMIT_W'($urandom());
      endcase
      return {(DATA_W - LIMIT_W)'($urandom()), lim};
   endfunction

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_PROP_GAIN:    kp = $signed(value);
         REG_INTEG_GAIN:   ki = $signed(value);
         REG_DERIV_GAIN:   kd = $signed(value);
         REG_INTEG_LIMIT:  integ_lim = value[LIMIT_W-1:0];
         REG_OUTPUT_LIMIT: out_lim = value[LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_tick(input req_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_q.push_back(predict_tick(t));
   endtask

   // The sender stops until every outstanding transaction has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic randomize_config();
      write_reg(REG_PROP_GAIN, pick_gain());
      write_reg(REG_INTEG_GAIN, pick_gain());
      write_reg(REG_DERIV_GAIN, pick_gain());
      write_reg(REG_INTEG_LIMIT, pick_limit());
      write_reg(REG_OUTPUT_LIMIT, pick_limit());
      if ($urandom_range(3) == 0)
         write_reg(IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)), $urandom());
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            if (mismatches < REPORT_LIMIT)
               $display("unexpected transaction: drive_current %0d locked %0b",
                        rsp_data.drive_current, rsp_data.locked);
            mismatches++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_data.drive_current !== want.drive_current ||
                rsp_data.locked !== want.locked) begin
               if (mismatches < REPORT_LIMIT)
                  $display("mismatch: drive_current exp %0d got %0d, locked exp %0b got %0b",
                           want.drive_current, rsp_data.drive_current,
                           want.locked, rsp_data.locked);
               mismatches++;
            end
         end
      end
      rsp_ready <= !rsp_holdoff && ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      forever begin
         wait (holdoff_request);
         rsp_holdoff <= 1'b1;
         repeat (HOLDOFF_CYCLES) @(posedge clock);
         rsp_holdoff <= 1'b0;
         holdoff_request = 1'b0;
      end
   end

   // With all gains and limits at zero the output stays zero in lock mode.
   task automatic test_reset_defaults();
      send_tick(tick_of(8191, 32767, 1'b1));
      send_tick(tick_of(0, -32768, 1'b1));
      send_tick(tick_of(4096, 1, 1'b0));
      wait_drained();
   endtask

   // Lock entry, free mode with integrator retained, re-entry and field extremes.
   task automatic test_hold_directed();
      write_reg(REG_PROP_GAIN, 32'h0001_0000);
      write_reg(REG_INTEG_GAIN, 32'h0000_8000);
      write_reg(REG_DERIV_GAIN, 32'hFFFF_C000);
      write_reg(REG_INTEG_LIMIT, 32'hFFFF_0064);
      write_reg(REG_OUTPUT_LIMIT, 32'h0000_03E8);
      write_reg(REG_SPARE_FIRST, 32'hFFFF_FFFF);
      write_reg(REG_SPARE_LAST, 32'h1234_5678);
      send_tick(tick_of(0, 0, 1'b0));
      send_tick(tick_of(8191, 32767, 1'b1));
      send_tick(tick_of(0, -32768, 1'b1));
      send_tick(tick_of(8191, 0, 1'b1));
      send_tick(tick_of(8100, 100, 1'b1));
      send_tick(tick_of(100, -32768, 1'b0));
      send_tick(tick_of(4000, 0, 1'b1));
      send_tick(tick_of(3990, 5, 1'b1));
      send_tick(tick_of(4010, -5, 1'b1));
      wait_drained();
   endtask

   task automatic test_zero_limits();
      write_reg(REG_INTEG_LIMIT, 32'h0000_0000);
      write_reg(REG_OUTPUT_LIMIT, 32'hFFFF_8000);
      send_tick(tick_of(4100, 3000, 1'b1));
      send_tick(tick_of(3000, -3000, 1'b1));
      wait_drained();
      write_reg(REG_OUTPUT_LIMIT, 32'h0000_7FFF);
      send_tick(tick_of(3900, 200, 1'b1));
      send_tick(tick_of(4300, -200, 1'b1));
      wait_drained();
   endtask

   // Full-scale gains drive the sum into both output clamps.
   task automatic test_gain_extremes();
      write_reg(REG_PROP_GAIN, 32'h7FFF_FFFF);
      write_reg(REG_INTEG_GAIN, 32'h8000_0000);
      write_reg(REG_DERIV_GAIN, 32'h7FFF_FFFF);
      write_reg(REG_INTEG_LIMIT, 32'h0000_7FFF);
      send_tick(tick_of(0, 0, 1'b0));
      send_tick(tick_of(0, 32767, 1'b1));
      send_tick(tick_of(8191, 0, 1'b1));
      wait_drained();
      write_reg(REG_PROP_GAIN, 32'h8000_0000);
      write_reg(REG_DERIV_GAIN, 32'h8000_0000);
      send_tick(tick_of(8191, -32768, 1'b1));
      send_tick(tick_of(0, 32767, 1'b1));
      wait_drained();
   endtask

   // The receiver stalls long enough for the block to fill and push back.
   task automatic test_receiver_holdoff();
      send_idle_pct   = 0;
      recv_idle_pct   = 0;
      gen_target      = ENCODER_BITS'($urandom());
      holdoff_request = 1'b1;
      repeat (24) send_tick(make_tick(1'b1, 1'b0));
      wait_drained();
   endtask

   task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                      input int count);
      int sent;
      int next_reconfig;
      sent          = 0;
      next_reconfig = 0;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      while (sent < count) begin
         if (sent >= next_reconfig) begin
            wait_drained();
            randomize_config();
            next_reconfig = sent + RECONFIG_EVERY;
         end
         if ($urandom_range(9) < 8) begin
            // A hold episode: up to two free ticks, then a lock run mostly around one point.
            gen_target = ENCODER_BITS'($urandom());
            repeat ($urandom_range(2)) begin
               send_tick(make_tick(1'b0, 1'b1));
               sent++;
            end
            repeat ($urandom_range(40, 1)) begin
               send_tick(make_tick(1'b1, $urandom_range(9) == 0));
               sent++;
            end
         end else begin
            repeat ($urandom_range(8, 1)) begin
               send_tick(make_tick($urandom_range(1), 1'b1));
               sent++;
            end
         end
      end
      wait_drained();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_hold_directed();
      test_zero_limits();
      test_gain_extremes();
      test_receiver_holdoff();
      test_random_traffic(6, 75, 600);
      test_random_traffic(75, 6, 600);
      test_random_traffic(0, 0, 600);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
